FILE: design/rwma_pkg.sv
// shared constants and types for the range wrapped modular alu
package rwma_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int SPAN_W      = VALUE_WIDTH + 1;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int DVD_W       = (PROD_W + 1 > 33) ? PROD_W + 1 : 33;
    localparam int MAG_W       = DVD_W - 1;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int OP_W        = 3;
    localparam int OPERAND_W   = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ASSIGN
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_MUL,
        ST_COMB,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        JOB_OFF,
        JOB_OPND,
        JOB_KMUL,
        JOB_CUR,
        JOB_START,
        JOB_PROD,
        JOB_ASSIGN
    } job_t;

endpackage

FILE: design/rwma_if.sv
// item channels of the range wrapped modular alu
interface rwma_in_if
    import rwma_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             op;
    logic signed [OPERAND_W-1:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

interface rwma_out_if
    import rwma_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

FILE: design/range_wrapped_modular_alu.sv
// range wrapped modular alu: held value, apb config and shared remainder sequencer
//
// in_ch carries one item (op, operand); out_ch returns one item (value, error) per input.
// range_start sits at apb address 0 and range_end at 4; writes take setup and access
// cycles, pready is tied high, reads return the sign-extended register.
// every remainder by the span runs on one shared restoring divider, one bit per
// cycle; a remainder job passes through load, one divide step per dividend bit, store.
// add, subtract and assign reduce their operands on the divider and then combine;
// multiply also forms a product, and divide scans the candidates (up to the span).
// an empty range, an unused op code or a multiply by 1 or less skips the divider.
// in_ch.ready is high only while no item is in work; the result sits in an output
// register, so a new item is taken while an earlier result still waits.
// when out_ch stalls, a finished item waits until the output register frees up.
// reset: range [0, 11], held value 0, no item in work, output empty.
module range_wrapped_modular_alu
    import rwma_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rwma_in_if.sink             in_ch,
    rwma_out_if.source          out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    state_t                        state_reg, state_next;
    job_t                          job_reg, job_next;
    op_t                           op_reg, op_next;
    logic signed [OPERAND_W-1:0]   operand_reg, operand_next;
    logic signed [VALUE_WIDTH-1:0] start_reg, end_reg;
    logic signed [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic                          err_reg, err_next;
    logic [VALUE_WIDTH-1:0]        off_reg, off_next;
    logic [VALUE_WIDTH-1:0]        b_reg, b_next;
    logic [VALUE_WIDTH-1:0]        k_reg, k_next;
    logic [VALUE_WIDTH-1:0]        a_reg, a_next;
    logic [VALUE_WIDTH-1:0]        p_reg, p_next;
    logic [VALUE_WIDTH-1:0]        idx_reg, idx_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;
    logic [VALUE_WIDTH-1:0]        rem_reg, rem_next;
    logic                          neg_reg, neg_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                          out_error_reg, out_error_next;

    logic                          cfg_wr;
    logic                          reg_sel;
    logic signed [SPAN_W-1:0]      diff;
    logic [SPAN_W-1:0]             span;
    logic [VALUE_WIDTH-1:0]        span_m1;
    logic                          empty;
    logic signed [DVD_W-1:0]       dvd;
    logic [MAG_W-1:0]              dvd_mag;
    logic [SPAN_W-1:0]             trial;
    logic [VALUE_WIDTH-1:0]        rem_step;
    logic [VALUE_WIDTH-1:0]        rem_fix;
    logic                          n_le1;
    logic [SPAN_W-1:0]             sum_ob;
    logic [VALUE_WIDTH-1:0]        add_r;
    logic [VALUE_WIDTH-1:0]        sub_r;
    logic [VALUE_WIDTH-1:0]        comb_r;
    logic [SPAN_W-1:0]             sum_ip;
    logic [VALUE_WIDTH-1:0]        trial_off;
    logic signed [SPAN_W-1:0]      tgt;
    logic                          hit;
    logic [SPAN_W-1:0]             sum_pk;
    logic [VALUE_WIDTH-1:0]        p_step;
    logic                          a_wrap;

    // config port
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[APB_AW-1];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_sel)
            REG_START: prdata = APB_DW'(start_reg);
            REG_END:   prdata = APB_DW'(end_reg);
            default:   prdata = '0;
        endcase
    end

    // range geometry
    assign diff    = SPAN_W'(end_reg) - SPAN_W'(start_reg);
    assign span    = diff + SPAN_W'(1);
    assign span_m1 = diff[VALUE_WIDTH-1:0];
    assign empty   = end_reg < start_reg;

    // dividend select for the shared remainder unit
    always_comb
    begin
        case (job_reg)
            JOB_OFF:    dvd = DVD_W'(cur_reg) - DVD_W'(start_reg);
            JOB_OPND:   dvd = DVD_W'(operand_reg);
            JOB_KMUL:   dvd = DVD_W'(operand_reg) - DVD_W'(1);
            JOB_CUR:    dvd = DVD_W'(cur_reg);
            JOB_START:  dvd = DVD_W'(start_reg);
            JOB_PROD:   dvd = DVD_W'(prod_reg);
            JOB_ASSIGN: dvd = DVD_W'(operand_reg) - DVD_W'(start_reg);
            default:    dvd = '0;
        endcase
    end

    assign dvd_mag = dvd[DVD_W-1] ? MAG_W'(-dvd) : MAG_W'(dvd);

    // one restoring step per cycle
    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_step = (trial >= span) ? VALUE_WIDTH'(trial - span) : trial[VALUE_WIDTH-1:0];
    // negative dividend: fold the remainder to the non-negative side
    assign rem_fix  = (neg_reg && rem_reg != '0) ?
                      VALUE_WIDTH'(span - SPAN_W'(rem_reg)) : rem_reg;

    assign n_le1 = operand_reg <= OPERAND_W'(1);

    // final combine of the reduced parts
    assign sum_ob = SPAN_W'(off_reg) + SPAN_W'(b_reg);
    assign add_r  = (sum_ob >= span) ? VALUE_WIDTH'(sum_ob - span) : sum_ob[VALUE_WIDTH-1:0];
    assign sub_r  = (off_reg >= b_reg) ? VALUE_WIDTH'(off_reg - b_reg) :
                    VALUE_WIDTH'(SPAN_W'(off_reg) + span - SPAN_W'(b_reg));

    always_comb
    begin
        case (op_reg)
            OP_SUB:    comb_r = sub_r;
            OP_ASSIGN: comb_r = b_reg;
            default:   comb_r = add_r;
        endcase
    end

    // divide scan: p tracks k * mod(start + idx) mod span incrementally
    assign sum_ip    = SPAN_W'(idx_reg) + SPAN_W'(p_reg);
    assign trial_off = (sum_ip >= span) ? VALUE_WIDTH'(sum_ip - span) : sum_ip[VALUE_WIDTH-1:0];
    assign tgt       = SPAN_W'(cur_reg) - SPAN_W'(start_reg);
    assign hit       = tgt == {1'b0, trial_off};
    assign sum_pk    = SPAN_W'(p_reg) + SPAN_W'(k_reg);
    assign p_step    = (sum_pk >= span) ? VALUE_WIDTH'(sum_pk - span) : sum_pk[VALUE_WIDTH-1:0];
    assign a_wrap    = a_reg == span_m1;

    assign in_ch.ready  = state_reg == ST_IDLE;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = out_value_reg;
    assign out_ch.error = out_error_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        op_next        = op_reg;
        operand_next   = operand_reg;
        cur_next       = cur_reg;
        err_next       = err_reg;
        off_next       = off_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next      = op_t'(in_ch.op);
                    operand_next = in_ch.operand;
                    err_next     = 1'b0;
                    state_next   = ST_FINISH;
                    if (empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        case (op_t'(in_ch.op)) inside
                            OP_ADD, OP_SUB:
                            begin
                                job_next   = JOB_OFF;
                                state_next = ST_LOAD;
                            end
                            OP_MUL:
                            begin
                                if (in_ch.operand > OPERAND_W'(1))
                                begin
                                    job_next   = JOB_OFF;
                                    state_next = ST_LOAD;
                                end
                            end
                            OP_DIV:
                            begin
                                job_next   = JOB_KMUL;
                                state_next = ST_LOAD;
                            end
                            OP_ASSIGN:
                            begin
                                job_next   = JOB_ASSIGN;
                                state_next = ST_LOAD;
                            end
                            default:
                            begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_LOAD:
            begin
                neg_next   = dvd[DVD_W-1];
                mag_next   = dvd_mag;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mag_next = mag_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                case (job_reg)
                    JOB_OFF:
                    begin
                        off_next   = rem_fix;
                        job_next   = (op_reg == OP_MUL) ? JOB_KMUL : JOB_OPND;
                        state_next = ST_LOAD;
                    end
                    JOB_OPND, JOB_ASSIGN:
                    begin
                        b_next     = rem_fix;
                        state_next = ST_COMB;
                    end
                    JOB_KMUL:
                    begin
                        // operand of 1 or less makes the trial product the candidate itself
                        k_next     = n_le1 ? '0 : rem_fix;
                        job_next   = (op_reg == OP_DIV) ? JOB_START : JOB_CUR;
                        state_next = ST_LOAD;
                    end
                    JOB_CUR, JOB_START:
                    begin
                        a_next     = rem_fix;
                        job_next   = JOB_PROD;
                        state_next = ST_MUL;
                    end
                    JOB_PROD:
                    begin
                        b_next     = rem_fix;
                        p_next     = rem_fix;
                        idx_next   = '0;
                        state_next = (op_reg == OP_DIV) ? ST_SCAN : ST_COMB;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(k_reg) * PROD_W'(a_reg);
                state_next = ST_LOAD;
            end
            ST_COMB:
            begin
                cur_next   = start_reg + comb_r;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    cur_next   = start_reg + idx_reg;
                    state_next = ST_FINISH;
                end
                else if (idx_reg == span_m1)
                begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + VALUE_WIDTH'(1);
                    a_next   = a_wrap ? '0 : a_reg + VALUE_WIDTH'(1);
                    p_next   = a_wrap ? '0 : p_step;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cur_reg;
                    out_error_next = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_OFF;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            end_reg       <= VALUE_WIDTH'(11);
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (reg_sel)
                    REG_START: start_reg <= pwdata[VALUE_WIDTH-1:0];
                    REG_END:   end_reg   <= pwdata[VALUE_WIDTH-1:0];
                    default:   start_reg <= start_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        operand_reg   <= operand_next;
        err_reg       <= err_next;
        off_reg       <= off_next;
        b_reg         <= b_next;
        k_reg         <= k_next;
        a_reg         <= a_next;
        p_reg         <= p_next;
        idx_reg       <= idx_next;
        prod_reg      <= prod_next;
        mag_reg       <= mag_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while an item is in work");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(MAG_W - 1)))
        else $error("divider ran past its last bit");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output loaded outside finish");

    a_no_err_on_combine: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMB) |-> !err_reg)
        else $error("error flagged on a combining op");

endmodule

FILE: bench/testbench.sv
// self-checking bench for the range wrapped modular alu: directed items, then random ranges
`timescale 1ns / 1ps

module testbench
    import rwma_pkg::*;
();

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          error;
    } alu_result_t;

    // tracks the held value and the configured range, queues the results each item should give
    class range_alu_tracker;
        longint                        held;
        logic signed [VALUE_WIDTH-1:0] range_lo;
        logic signed [VALUE_WIDTH-1:0] range_hi;
        alu_result_t                   pending_results[$];
        int                            errors;
        int                            results_seen;

        function new();
            held = 0;
            range_lo = 0;
            range_hi = 11;
            errors = 0;
            results_seen = 0;
        endfunction

        function longint mod_pos(longint a, longint m);
            longint r;
            r = a % m;
            if (r < 0)
                r += m;
            return r;
        endfunction

        // start + mod(base - start + (n-1)*base, span), reduced piecewise
        function longint wrapped_product(longint base, longint n, longint lo, longint span);
            longint off, k, a;
            if (n <= 1)
                return base;
            off = mod_pos(base - lo, span);
            k = mod_pos(n - 1, span);
            a = mod_pos(base, span);
            return lo + mod_pos(off + mod_pos(k * a, span), span);
        endfunction

        function void set_range(logic idx, logic signed [VALUE_WIDTH-1:0] val);
            if (idx == REG_START)
                range_lo = val;
            else
                range_hi = val;
        endfunction

        function void accept_item(logic [OP_W-1:0] op, logic signed [OPERAND_W-1:0] operand);
            longint      n, lo, hi, span, off;
            bit          found;
            alu_result_t r;
            n = operand;
            lo = range_lo;
            hi = range_hi;
            r.error = 1'b0;
            if (hi < lo) begin
                r.error = 1'b1;
            end
            else begin
                span = hi - lo + 1;
                case (op)
                    OP_ADD:
                        held = lo + mod_pos(mod_pos(held - lo, span) + mod_pos(n, span), span);
                    OP_SUB:
                        held = lo + mod_pos(mod_pos(held - lo, span) - mod_pos(n, span), span);
                    OP_MUL:
                        held = wrapped_product(held, n, lo, span);
                    OP_DIV:
                    begin
                        found = 1'b0;
                        for (off = 0; off < span; off++) begin
                            if (wrapped_product(lo + off, n, lo, span) == held) begin
                                found = 1'b1;
                                break;
                            end
                        end
                        if (found)
                            held = lo + off;
                        else
                            r.error = 1'b1;
                    end
                    OP_ASSIGN:
                        held = lo + mod_pos(n - lo, span);
                    default:
                        ;
                endcase
            end
            r.value = held[VALUE_WIDTH-1:0];
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            errors++;
        endtask

        task check_result(logic signed [VALUE_WIDTH-1:0] value, logic error);
            alu_result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item value %0d error %0b", value, error));
            end
            else begin
                want = pending_results.pop_front();
                if (value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d", value, want.value));
                if (error !== want.error)
                    report_mismatch($sformatf("error %0b, want %0b", error, want.error));
            end
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rwma_in_if  in_bus();
    rwma_out_if out_bus();

    range_wrapped_modular_alu dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    range_alu_tracker tracker;
    int send_idle_pct;
    int recv_idle_pct;
    int sent_count;

    always #2 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.op = '0;
        in_bus.operand = '0;
        out_bus.ready = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 87;
        sent_count = 0;
        tracker = new();
    end

    always @(negedge clk)
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
            tracker.accept_item(in_bus.op, in_bus.operand);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            tracker.check_result(out_bus.value, out_bus.error);
    end

    // entered and left at a falling edge; valid stays high across back-to-back items
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [OPERAND_W-1:0] val);
        if (sent_count < 490) begin
            send_idle_pct = 19;
            recv_idle_pct = 87;
        end
        else if (sent_count < 980) begin
            send_idle_pct = 87;
            recv_idle_pct = 19;
        end
        else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.op <= op;
        in_bus.operand <= val;
        do
            @(posedge clk);
        while (!in_bus.ready);
        @(negedge clk);
        sent_count++;
    endtask

    // drops valid, then waits for every expected result
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_range(idx, val[VALUE_WIDTH-1:0]);
        @(negedge clk);
    endtask

    task automatic set_range(input int lo, input int hi);
        wait_idle();
        apb_write(REG_START, lo);
        apb_write(REG_END, hi);
    endtask

    function automatic int rand_operand(int span);
        int m;
        m = (span < 1) ? 16 : span;
        case ($urandom_range(9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    3: return 1;
                    4: return -1;
                    default: return 2;
                endcase
            end
            3: return m * (int'($urandom_range(6)) - 3) + int'($urandom_range(2)) - 1;
            default: return int'($urandom_range(6 * m)) - 3 * m;
        endcase
    endfunction

    initial
    begin : stimulus
        int          lo, hi, span, wide_divs, r;
        logic [OP_W-1:0] op;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset range [0, 11]
        send_item(OP_ADD, 0);
        send_item(OP_ADD, 32'sh7fff_ffff);
        send_item(OP_ADD, 32'sh8000_0000);
        send_item(OP_SUB, -1);
        send_item(OP_SUB, 32'sh8000_0000);
        send_item(OP_MUL, 0);
        send_item(OP_MUL, 1);
        send_item(OP_MUL, -5);
        send_item(OP_MUL, 2);
        send_item(OP_MUL, 32'sh7fff_ffff);
        send_item(OP_DIV, 1);
        send_item(OP_DIV, 3);
        send_item(OP_DIV, 0);
        send_item(OP_DIV, -7);
        send_item(OP_ASSIGN, -1);
        send_item(OP_ASSIGN, 32'sh8000_0000);
        send_item(OP_ASSIGN, 32'sh7fff_ffff);
        send_item(3'd5, 7);
        send_item(3'd6, -7);
        send_item(3'd7, 32'sh7fff_ffff);
        // empty range
        set_range(0, -1);
        send_item(OP_ADD, 3);
        send_item(OP_DIV, 1);
        // held value left outside a moved range
        set_range(100, 110);
        send_item(OP_DIV, 1);
        send_item(OP_ASSIGN, 5);

        for (int blk = 0; blk < 16; blk++) begin
            case (blk)
                0: begin lo = -5;     hi = 20;     end
                1: begin lo = -32768; hi = 32767;  end
                2: begin lo = 32767;  hi = 32767;  end
                3: begin lo = -32768; hi = -32768; end
                4: begin lo = 10;     hi = 3;      end
                5: begin lo = 32767;  hi = -32768; end
                6: begin lo = -32768; hi = -32700; end
                7: begin lo = 32640;  hi = 32767;  end
                8: begin lo = -1;     hi = 1;      end
                9: begin lo = 0;      hi = 0;      end
                default:
                begin
                    lo = int'($urandom_range(65535)) - 32768;
                    hi = lo + int'($urandom_range(249));
                    if (hi > 32767)
                        hi = 32767;
                end
            endcase
            set_range(lo, hi);
            span = hi - lo + 1;
            wide_divs = 0;
            for (int i = 0; i < 90; i++) begin
                r = $urandom_range(99);
                if (r < 5)
                    op = 3'($urandom_range(7, 5));
                else
                    op = 3'(r % 5);
                // a divide over a huge range can scan tens of thousands of candidates
                if (span > 2048 && op == OP_DIV) begin
                    if (wide_divs >= 3)
                        op = OP_ADD;
                    else
                        wide_divs++;
                end
                if ($urandom_range(59) == 0)
                    wait_idle();
                send_item(op, rand_operand(span));
            end
        end

        wait_idle();
        repeat (300) @(negedge clk);
        if (tracker.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
